>>> design/srt_pkg.sv
// ----------------------------------------------------------------------------
// srt_pkg
// Shared types, constants and helpers for the segment receive tracker.
// ----------------------------------------------------------------------------
package srt_pkg;

    localparam int SEQ_BITS_DEF   = 16;
    localparam int MAX_WINDOW_DEF = 32;

    // Bitmap rows: 32 segment numbers per memory word
    localparam int MAP_W     = 32;
    localparam int MAP_OFF_W = 5;

    // Flag bit positions
    localparam int FLAG_DAT = 0;
    localparam int FLAG_RWA = 1;
    localparam int FLAG_EOM = 2;

    // Item function codes
    localparam logic FUNC_SEG  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // Reply kinds
    localparam logic KIND_RWA  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam int WIN_OUT_W = 6;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_map_ctl;

    typedef struct packed {
        logic clearing;
        logic busy;
    } t_ctl_status;

    typedef struct packed {
        logic        kind;
        logic        ack_valid;
        logic [15:0] ack_num;
        logic [5:0]  window;
    } t_reply;

    // Position of the lowest set bit; zero when none is set
    function automatic logic [MAP_OFF_W-1:0] first_set(input logic [MAP_W-1:0] x);
        logic [MAP_OFF_W-1:0] p;
        p = '0;
        for (int i = MAP_W - 1; i >= 0; i--) begin
            if (x[i]) p = MAP_OFF_W'(i);
        end
        return p;
    endfunction

endpackage

>>> design/srt_map_ram.sv
// ----------------------------------------------------------------------------
// srt_map_ram
// Received bitmap store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module srt_map_ram
    import srt_pkg::*;
#(
    parameter int ROW_W = SEQ_BITS_DEF - MAP_OFF_W
) (
    input  logic             i_clk,
    input  t_map_ctl         i_ctl,
    input  logic [ROW_W-1:0] i_wr_addr,
    input  logic [MAP_W-1:0] i_wr_data,
    input  logic [ROW_W-1:0] i_rd_addr,
    output logic [MAP_W-1:0] o_rd_data
);

    logic [MAP_W-1:0] mem [2**ROW_W];

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) mem[i_wr_addr] <= i_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) o_rd_data <= mem[i_rd_addr];
    end

endmodule

>>> design/srt_ctrl.sv
// ----------------------------------------------------------------------------
// srt_ctrl
// Sequencer: bitmap clearing, read-modify-write of data segments, row-wise
// run extension, window credit and reply composition.
// ----------------------------------------------------------------------------
module srt_ctrl
    import srt_pkg::*;
#(
    parameter int SEQ_BITS   = SEQ_BITS_DEF,
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_func,
    input  logic [7:0]                    i_seg_flags,
    input  logic [15:0]                   i_seg_num,
    input  logic                          i_slot_free,
    output logic                          o_push,
    output t_reply                        o_reply,
    output t_ctl_status                   o_status,
    output t_map_ctl                      o_map_ctl,
    output logic [SEQ_BITS-MAP_OFF_W-1:0] o_wr_addr,
    output logic [MAP_W-1:0]              o_wr_data,
    output logic [SEQ_BITS-MAP_OFF_W-1:0] o_rd_addr,
    input  logic [MAP_W-1:0]              i_rd_data
);

    localparam int ROW_W = SEQ_BITS - MAP_OFF_W;
    localparam int WIN_W = $clog2(MAX_WINDOW + 1);
    localparam logic [SEQ_BITS-1:0] SEQ_MASK = {SEQ_BITS{1'b1}};
    localparam logic [ROW_W-1:0]    ROW_LAST = {ROW_W{1'b1}};

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_LOOK  = 3'd2;
    localparam logic [2:0] ST_XRD   = 3'd3;
    localparam logic [2:0] ST_XCHK  = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0]           r_state,    n_state;
    logic [ROW_W-1:0]     r_clr,      n_clr;
    logic [SEQ_BITS-1:0]  r_num,      n_num;
    logic [SEQ_BITS-1:0]  r_lowest,   n_lowest;
    logic [SEQ_BITS-1:0]  r_run_end,  n_run_end;
    logic                 r_any,      n_any;
    logic [WIN_W-1:0]     r_win,      n_win;
    logic                 r_finished, n_finished;
    logic [ROW_W-1:0]     r_scan_row, n_scan_row;
    logic [MAP_OFF_W-1:0] r_scan_off, n_scan_off;
    t_reply               r_rep,      n_rep;

    logic                 accept;
    logic [SEQ_BITS-1:0]  in_num;
    logic [WIN_W-1:0]     win_dec;
    logic [WIN_W-1:0]     win_next;
    logic [MAP_W-1:0]     bit_mask;
    logic [MAP_W-1:0]     zeros;
    logic [ROW_W-1:0]     row_next;
    logic [SEQ_BITS-1:0]  row_end;
    logic [SEQ_BITS-1:0]  run_next;

    function automatic logic [WIN_OUT_W-1:0] win_field(input logic [WIN_W-1:0] w);
        if (32'(w) > 63) return WIN_OUT_W'(63);
        return WIN_OUT_W'(w);
    endfunction

    assign accept   = i_in_valid && (r_state == ST_IDLE);
    assign in_num   = i_seg_num[SEQ_BITS-1:0];
    assign win_dec  = (r_win != '0) ? r_win - WIN_W'(1) : r_win;
    assign win_next = (win_dec == '0) ? WIN_W'(MAX_WINDOW) : win_dec;
    assign bit_mask = MAP_W'(1) << r_num[MAP_OFF_W-1:0];
    // zero bits at or above the scan start offset
    assign zeros    = ~i_rd_data & ~((MAP_W'(1) << r_scan_off) - MAP_W'(1));
    assign row_next = r_scan_row + ROW_W'(1);
    assign row_end  = {r_scan_row, {MAP_OFF_W{1'b1}}};
    assign run_next = r_run_end + SEQ_BITS'(1);

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_num      = r_num;
        n_lowest   = r_lowest;
        n_run_end  = r_run_end;
        n_any      = r_any;
        n_win      = r_win;
        n_finished = r_finished;
        n_scan_row = r_scan_row;
        n_scan_off = r_scan_off;
        n_rep      = r_rep;
        o_map_ctl  = '0;
        o_wr_addr  = '0;
        o_wr_data  = '0;
        o_rd_addr  = '0;
        o_push     = 1'b0;

        unique case (r_state)
            ST_CLEAR: begin
                o_map_ctl.wr_en = 1'b1;
                o_wr_addr       = r_clr;
                n_clr           = r_clr + ROW_W'(1);
                if (r_clr == ROW_LAST) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept && !r_finished) begin
                    n_rep.ack_valid = r_any;
                    n_rep.ack_num   = r_any ? 16'(r_run_end) : 16'd0;
                    if (i_func == FUNC_TICK) begin
                        n_rep.kind   = KIND_TICK;
                        n_rep.window = win_field(r_win);
                        if (r_any) n_state = ST_EMIT;
                    end else if (i_seg_flags[FLAG_DAT]) begin
                        n_win           = win_next;
                        n_num           = in_num;
                        o_map_ctl.rd_en = 1'b1;
                        o_rd_addr       = in_num[SEQ_BITS-1:MAP_OFF_W];
                        n_state         = ST_LOOK;
                    end else if (i_seg_flags[FLAG_RWA]) begin
                        n_win        = win_next;
                        n_rep.kind   = KIND_RWA;
                        n_rep.window = win_field(win_dec);
                        n_state      = ST_EMIT;
                    end else if (i_seg_flags[FLAG_EOM]) begin
                        // no reload after end of message
                        n_win      = win_dec;
                        n_finished = 1'b1;
                    end else begin
                        n_win = win_next;
                    end
                end
            end
            ST_LOOK: begin
                if ((i_rd_data & bit_mask) != '0) begin
                    n_state = ST_IDLE;
                end else begin
                    o_map_ctl.wr_en = 1'b1;
                    o_wr_addr       = r_num[SEQ_BITS-1:MAP_OFF_W];
                    o_wr_data       = i_rd_data | bit_mask;
                    if (!r_any || r_num < r_lowest) begin
                        n_any     = 1'b1;
                        n_lowest  = r_num;
                        n_run_end = r_num;
                        n_state   = (r_num == SEQ_MASK) ? ST_IDLE : ST_XRD;
                    end else if (r_run_end != SEQ_MASK && r_num == run_next) begin
                        n_state = ST_XRD;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_XRD: begin
                // row write landed at the last edge, so this read sees it
                o_map_ctl.rd_en = 1'b1;
                o_rd_addr       = run_next[SEQ_BITS-1:MAP_OFF_W];
                n_scan_row      = run_next[SEQ_BITS-1:MAP_OFF_W];
                n_scan_off      = run_next[MAP_OFF_W-1:0];
                n_state         = ST_XCHK;
            end
            ST_XCHK: begin
                if (zeros == '0) begin
                    n_run_end = row_end;
                    if (row_end == SEQ_MASK) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_map_ctl.rd_en = 1'b1;
                        o_rd_addr       = row_next;
                        n_scan_row      = row_next;
                        n_scan_off      = '0;
                    end
                end else begin
                    n_run_end = {r_scan_row, first_set(zeros)} - SEQ_BITS'(1);
                    n_state   = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (i_slot_free) begin
                    o_push  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr      <= '0;
            r_lowest   <= '0;
            r_run_end  <= '0;
            r_any      <= 1'b0;
            r_win      <= WIN_W'(MAX_WINDOW);
            r_finished <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr      <= n_clr;
            r_lowest   <= n_lowest;
            r_run_end  <= n_run_end;
            r_any      <= n_any;
            r_win      <= n_win;
            r_finished <= n_finished;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num      <= n_num;
        r_scan_row <= n_scan_row;
        r_scan_off <= n_scan_off;
        r_rep      <= n_rep;
    end

    assign o_reply           = r_rep;
    assign o_status.clearing = (r_state == ST_CLEAR);
    assign o_status.busy     = (r_state != ST_IDLE);

endmodule

>>> design/segment_receive_tracker.sv
// ----------------------------------------------------------------------------
// segment_receive_tracker
// Sliding-window receiver with cumulative acknowledgement over a received
// bitmap held in a row-wide synchronous memory.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------------
//  in      | sink      | i_in_valid / o_in_stall    | i_func i_seg_flags i_seg_num
//  out     | source    | o_out_valid / i_out_stall  | o_reply_kind o_ack_valid
//          |           |                            | o_ack_num o_window_adv
//
// A tick with data or a window request goes through the reply state; other
// non-data items end in idle. A data segment is read and, if new, written
// back; if its run grows, the extension reads and checks each bitmap row (32
// numbers) walked. After reset a clearing pass of all 2**SEQ_BITS/32 rows (2048
// by default) holds o_in_stall high. A reply waits in the output register; the
// next item is taken meanwhile and only a further reply holds until it frees.
// ----------------------------------------------------------------------------
module segment_receive_tracker
    import srt_pkg::*;
#(
    parameter int SEQ_BITS   = SEQ_BITS_DEF,
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_func,
    input  logic [7:0]  i_seg_flags,
    input  logic [15:0] i_seg_num,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_reply_kind,
    output logic        o_ack_valid,
    output logic [15:0] o_ack_num,
    output logic [5:0]  o_window_adv
);

    localparam int ROW_W = SEQ_BITS - MAP_OFF_W;

    t_map_ctl         map_ctl;
    t_ctl_status      status;
    t_reply           reply;
    logic             push;
    logic             slot_free;
    logic [ROW_W-1:0] wr_addr;
    logic [ROW_W-1:0] rd_addr;
    logic [MAP_W-1:0] wr_data;
    logic [MAP_W-1:0] rd_data;

    logic             r_out_valid;
    t_reply           r_out;

    assign slot_free = !r_out_valid || !i_out_stall;

    srt_ctrl #(
        .SEQ_BITS   (SEQ_BITS),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_func      (i_func),
        .i_seg_flags (i_seg_flags),
        .i_seg_num   (i_seg_num),
        .i_slot_free (slot_free),
        .o_push      (push),
        .o_reply     (reply),
        .o_status    (status),
        .o_map_ctl   (map_ctl),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    srt_map_ram #(
        .ROW_W (ROW_W)
    ) u_map (
        .i_clk     (i_clk),
        .i_ctl     (map_ctl),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // output holding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_out <= reply;
    end

    assign o_in_stall   = status.busy;
    assign o_out_valid  = r_out_valid;
    assign o_reply_kind = r_out.kind;
    assign o_ack_valid  = r_out.ack_valid;
    assign o_ack_num    = r_out.ack_num;
    assign o_window_adv = r_out.window;

    a_push_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> slot_free)
        else $error("reply pushed over a held result");

    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> o_out_valid)
        else $error("pushed reply not presented");

    a_clear_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.clearing |-> o_in_stall)
        else $error("input taken during bitmap clearing");

    a_no_push_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.clearing |-> !push && !map_ctl.rd_en)
        else $error("bitmap activity during clearing pass");

endmodule

>>> test/srt_reply_checker.sv
// ----------------------------------------------------------------------------
// srt_reply_checker
// Watches both channels of the segment receive tracker, predicts the reply
// for every accepted tick with data or window request and compares each accepted reply,
// field by field, with the oldest prediction outstanding.
// ----------------------------------------------------------------------------
module srt_reply_checker
    import srt_pkg::*;
#(
    parameter int SEQ_BITS   = SEQ_BITS_DEF,
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_func,
    input  logic [7:0]  i_seg_flags,
    input  logic [15:0] i_seg_num,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_reply_kind,
    input  logic        i_ack_valid,
    input  logic [15:0] i_ack_num,
    input  logic [5:0]  i_window_adv,
    output int          o_fail_count,
    output int          o_replies_due
);

    localparam int unsigned SEQ_TOP = (1 << SEQ_BITS) - 1;

    bit          rx_map [0:SEQ_TOP];
    int unsigned lowest_num;
    int unsigned run_top;
    int unsigned credits;
    bit          have_data;
    bit          msg_done;
    t_reply      replies_due_q [$];

    function automatic t_reply reply_now(input logic kind);
        t_reply r;
        r.kind      = kind;
        r.ack_valid = have_data;
        r.ack_num   = have_data ? 16'(run_top) : 16'd0;
        r.window    = (credits > 63) ? 6'd63 : 6'(credits);
        return r;
    endfunction

    // Run never wraps past the largest number
    task automatic walk_run();
        while (run_top < SEQ_TOP && rx_map[run_top + 1])
            run_top++;
    endtask

    task automatic track_segment(input logic func, input logic [7:0] flags,
                                 input logic [15:0] num);
        int unsigned n;
        n = num & SEQ_TOP;
        if (msg_done)
            return;
        if (func == FUNC_TICK) begin
            if (have_data)
                replies_due_q.push_back(reply_now(KIND_TICK));
            return;
        end
        if (credits > 0)
            credits--;
        if (flags[FLAG_DAT]) begin
            if (!rx_map[n]) begin
                rx_map[n] = 1'b1;
                if (!have_data || n < lowest_num) begin
                    have_data  = 1'b1;
                    lowest_num = n;
                    run_top    = n;
                    walk_run();
                end else if (run_top < SEQ_TOP && n == run_top + 1) begin
                    walk_run();
                end
            end
        end else if (flags[FLAG_RWA]) begin
            replies_due_q.push_back(reply_now(KIND_RWA));
        end else if (flags[FLAG_EOM]) begin
            // end of message: no reload, everything after is dropped
            msg_done = 1'b1;
            return;
        end
        if (credits == 0)
            credits = MAX_WINDOW;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t srt_reply_checker: %s expected %0d actual %0d",
                     $time, name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_reply want;
        if (!i_rst_n) begin
            for (int i = 0; i <= SEQ_TOP; i++)
                rx_map[i] = 1'b0;
            lowest_num   = 0;
            run_top      = 0;
            credits      = MAX_WINDOW;
            have_data    = 1'b0;
            msg_done     = 1'b0;
            o_fail_count = 0;
            replies_due_q.delete();
        end else begin
            // reply side first: anything leaving now was predicted earlier
            if (i_out_valid && !i_out_stall) begin
                if (replies_due_q.size() == 0) begin
                    $display("%0t srt_reply_checker: reply expected none actual kind %0d ack_valid %0d ack %0d window %0d",
                             $time, i_reply_kind, i_ack_valid, i_ack_num, i_window_adv);
                    o_fail_count++;
                end else begin
                    want = replies_due_q.pop_front();
                    check_field("reply_kind", want.kind, i_reply_kind);
                    check_field("ack_valid", want.ack_valid, i_ack_valid);
                    check_field("ack_num", want.ack_num, i_ack_num);
                    check_field("window_adv", want.window, i_window_adv);
                end
            end
            if (i_in_valid && !i_in_stall)
                track_segment(i_func, i_seg_flags, i_seg_num);
        end
        o_replies_due <= replies_due_q.size();
    end

endmodule

>>> test/tb_segment_receive_tracker.sv
// ----------------------------------------------------------------------------
// tb_segment_receive_tracker
// Drives segment headers and timer ticks into the receive tracker in random
// bursts against a randomly stalling reply side, with one long hold-off to
// back the block up; the reply checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_segment_receive_tracker;
    import srt_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int DRAIN_CYCLES    = 2200;    // one full-map run walk plus margin
    localparam int RANDOM_ITEMS    = 1650;
    localparam int HOLD_OFF_AFTER  = 300;
    localparam int HOLD_OFF_CYCLES = 400;

    localparam logic [7:0] F_DAT = 8'(1 << FLAG_DAT);
    localparam logic [7:0] F_RWA = 8'(1 << FLAG_RWA);
    localparam logic [7:0] F_EOM = 8'(1 << FLAG_EOM);

    typedef struct packed {
        logic        func;
        logic [7:0]  flags;
        logic [15:0] num;
    } t_seg_item;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic        func      = FUNC_SEG;
    logic [7:0]  seg_flags = '0;
    logic [15:0] seg_num   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        reply_kind;
    logic        ack_valid;
    logic [15:0] ack_num;
    logic [5:0]  window_adv;

    t_seg_item   stream_q [$];
    int          sent_count  = 0;
    bit          sent_all    = 1'b0;
    bit          held_off    = 1'b0;
    int          cycle_count = 0;
    int          fail_count;
    int          replies_due;

    segment_receive_tracker DUT (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_func       (func),
        .i_seg_flags  (seg_flags),
        .i_seg_num    (seg_num),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_reply_kind (reply_kind),
        .o_ack_valid  (ack_valid),
        .o_ack_num    (ack_num),
        .o_window_adv (window_adv)
    );

    srt_reply_checker checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_func        (func),
        .i_seg_flags   (seg_flags),
        .i_seg_num     (seg_num),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_reply_kind  (reply_kind),
        .i_ack_valid   (ack_valid),
        .i_ack_num     (ack_num),
        .i_window_adv  (window_adv),
        .o_fail_count  (fail_count),
        .o_replies_due (replies_due)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic t_seg_item seg(input logic f, input logic [7:0] fl,
                                      input logic [15:0] n);
        t_seg_item s;
        s.func  = f;
        s.flags = fl;
        s.num   = n;
        return s;
    endfunction

    task automatic build_stream();
        int unsigned base;
        int unsigned pick;
        logic [15:0] n;
        // directed opening
        stream_q.push_back(seg(FUNC_TICK, F_EOM, 16'hFFFF));     // tick, no data yet
        stream_q.push_back(seg(FUNC_SEG, F_RWA, 16'h0000));      // request, no ack
        stream_q.push_back(seg(FUNC_SEG, 8'h00, 16'h1234));      // no known flag
        stream_q.push_back(seg(FUNC_SEG, 8'hF8, 16'hABCD));      // only unused bits
        stream_q.push_back(seg(FUNC_SEG, 8'hFF, 16'hFFFF));      // data beats all
        stream_q.push_back(seg(FUNC_SEG, F_DAT, 16'hFFFE));      // lower, run hits top
        stream_q.push_back(seg(FUNC_TICK, 8'h00, 16'h0000));
        stream_q.push_back(seg(FUNC_SEG, F_RWA | F_EOM, 16'h5555)); // request beats eom
        stream_q.push_back(seg(FUNC_SEG, F_DAT | F_EOM, 16'hFFFF)); // duplicate
        stream_q.push_back(seg(FUNC_SEG, F_DAT, 16'h0000));      // new lowest
        stream_q.push_back(seg(FUNC_SEG, F_DAT | F_RWA, 16'h0001));
        stream_q.push_back(seg(FUNC_SEG, F_DAT, 16'h0003));      // gap
        stream_q.push_back(seg(FUNC_TICK, 8'hFF, 16'hFFFF));
        stream_q.push_back(seg(FUNC_SEG, F_DAT, 16'h0002));      // fills gap
        stream_q.push_back(seg(FUNC_SEG, 8'hFE, 16'h0000));
        stream_q.push_back(seg(FUNC_TICK, 8'h00, 16'h0000));
        // random body
        base = 4;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                case ($urandom_range(0, 9))
                    0:       n = 16'($urandom);
                    1:       n = 16'hFFC0 + 16'($urandom_range(0, 63));
                    default: n = 16'(base + $urandom_range(0, 47));
                endcase
                base += $urandom_range(0, 1);
                stream_q.push_back(seg(FUNC_SEG, 8'($urandom) | F_DAT, n));
            end else if (pick < 70) begin
                stream_q.push_back(seg(FUNC_SEG, (8'($urandom) | F_RWA) & ~F_DAT,
                                       16'($urandom)));
            end else if (pick < 85) begin
                stream_q.push_back(seg(FUNC_TICK, 8'($urandom), 16'($urandom)));
            end else begin
                stream_q.push_back(seg(FUNC_SEG, 8'($urandom) & ~(F_DAT | F_RWA | F_EOM),
                                       16'($urandom)));
            end
        end
        // end of message, then items that must be dropped
        stream_q.push_back(seg(FUNC_SEG, 8'hFC, 16'($urandom)));
        stream_q.push_back(seg(FUNC_TICK, 8'h00, 16'h0000));
        stream_q.push_back(seg(FUNC_SEG, F_RWA, 16'h0000));
        stream_q.push_back(seg(FUNC_SEG, F_DAT, 16'h0004));
        stream_q.push_back(seg(FUNC_SEG, F_EOM, 16'h0000));
    endtask

    // sender: bursts of transfers with random gaps
    initial begin : drive
        int burst;
        int gap;
        build_stream();
        wait (rst_n == 1'b1);
        @(posedge clk);
        while (sent_count < stream_q.size()) begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 12);
            while (burst > 0 && sent_count < stream_q.size()) begin
                in_valid  <= 1'b1;
                func      <= stream_q[sent_count].func;
                seg_flags <= stream_q[sent_count].flags;
                seg_num   <= stream_q[sent_count].num;
                do @(posedge clk); while (in_stall);
                sent_count++;
                burst--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0 || sent_count == stream_q.size()) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        sent_all = 1'b1;
    end

    // receiver: stall pattern in stretches, plus one long hold-off
    initial begin : receive
        int len;
        int mode;
        wait (rst_n == 1'b1);
        forever begin
            if (!held_off && sent_count >= HOLD_OFF_AFTER) begin
                held_off = 1'b1;
                out_stall <= 1'b1;
                for (int c = 0; c < HOLD_OFF_CYCLES; c++)
                    @(posedge clk);
            end else begin
                len  = $urandom_range(4, 60);
                mode = $urandom_range(0, 3);
                repeat (len) begin
                    case (mode)
                        0:       out_stall <= 1'b0;
                        1:       out_stall <= ($urandom_range(0, 3) == 0);
                        2:       out_stall <= ($urandom_range(0, 1) == 0);
                        default: out_stall <= ($urandom_range(0, 3) != 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    initial begin : verdict
        wait (sent_all);
        @(posedge clk);
        while (replies_due != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("[segment_receive_tracker] OK");
        end else begin
            $display("[segment_receive_tracker] ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("[segment_receive_tracker] ERROR");
        $finish;
    end

endmodule

>>> files.f
design/srt_pkg.sv
design/srt_map_ram.sv
design/srt_ctrl.sv
design/segment_receive_tracker.sv
test/srt_reply_checker.sv
test/tb_segment_receive_tracker.sv
